// File: hw/rtl/flrc_pkg.sv
package flrc_pkg;

   // Fixed field widths of the request and response items
   localparam int REQ_W    = 2;
   localparam int LOC_W    = 16;
   localparam int SIZE_W   = 17;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 6;

   typedef logic [REQ_W-1:0]   req_code_type;
   typedef logic [LOC_W-1:0]   loc_type;
   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [COUNT_W-1:0] count_type;

   // Request codes; the fourth code is unused and gets an ignored status
   localparam req_code_type REQ_APPEND  = 2'd0;
   localparam req_code_type REQ_RELEASE = 2'd1;
   localparam req_code_type REQ_DUMP    = 2'd2;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_LOWER    = 3'd1,
      ST_UPPER    = 3'd2,
      ST_BOTH     = 3'd3,
      ST_IGNORED  = 3'd4,
      ST_FULL     = 3'd5,
      ST_ENTRY    = 3'd6,
      ST_EMPTY    = 3'd7
   } status_type;

   // One free-list entry as stored in the list RAM
   typedef struct packed {
      loc_type  start;
      size_type length;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Read address select
   typedef enum logic [2:0] {
      RD_ZERO,
      RD_IDX_NEXT,
      RD_LAST,
      RD_J_NEXT,
      RD_J_PREV
   } rd_sel_type;

   // Write address / data select
   typedef enum logic [2:0] {
      WR_APPEND,
      WR_INSERT,
      WR_LOWER,
      WR_BOTH,
      WR_UPPER,
      WR_SHUP,
      WR_SHDN
   } wr_sel_type;

   // Counter operations for the scan index and the entry count
   typedef enum logic [1:0] {
      CTR_HOLD,
      CTR_CLEAR,
      CTR_INC,
      CTR_DEC
   } ctr_op_type;

   // Shift index operations
   typedef enum logic [2:0] {
      J_HOLD,
      J_LOAD_LAST,
      J_LOAD_NEXT,
      J_INC,
      J_DEC
   } j_op_type;

   // Controller to datapath
   typedef struct packed {
      logic       req_ready;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      ctr_op_type idx_op;
      j_op_type   j_op;
      ctr_op_type cnt_op;
      logic       prev_ld;
      logic       cur_ld;
      logic       at_end_ld;
      logic       at_end_val;
      logic       st_ld;
      status_type st_val;
      logic       rsp_ld;
      logic       rsp_entry_ld;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_valid;
      logic is_dump;
      logic is_release;
      logic ignored;
      logic out_of_range;
      logic full;
      logic empty;
      logic scan_le;
      logic idx_last;
      logic at_end;
      logic lower_hit;
      logic upper_hit;
      logic j_at_idx;
      logic j_last;
      logic rsp_free;
   } stat_type;

endpackage

// File: hw/rtl/flrc_req_if.sv
interface flrc_req_if;
   logic                   valid;
   logic                   ready;
   flrc_pkg::req_code_type req_type;
   flrc_pkg::loc_type      block_loc;
   flrc_pkg::size_type     block_size;

   modport source (output valid, output req_type, output block_loc, output block_size,
                   input ready);
   modport sink   (input valid, input req_type, input block_loc, input block_size,
                   output ready);
endinterface

// File: hw/rtl/flrc_rsp_if.sv
interface flrc_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [flrc_pkg::STATUS_W-1:0] status;
   flrc_pkg::loc_type      entry_loc;
   flrc_pkg::size_type     entry_size;
   logic                   last;
   flrc_pkg::count_type    entry_count;

   modport source (output valid, output status, output entry_loc, output entry_size,
                   output last, output entry_count, input ready);
   modport sink   (input valid, input status, input entry_loc, input entry_size,
                   input last, input entry_count, output ready);
endinterface

// File: hw/rtl/free_list_release_coalesce_core.sv
// Channel  Dir  Handshake     Item
// req_ch   in   valid/ready   req_type, block_loc, block_size
// rsp_ch   out  valid/ready   status, entry_loc, entry_size, last, entry_count
//
// Append, ignored, rejected and empty-dump items: status set in EVAL, result loaded in FINISH.
// Release: SCAN reads entries from the head until one starts above block_loc or the list ends,
// then DECIDE sets the status; a plain insert below the tail first shifts the tail up (SHUP,
// INSWR), a merge with both neighbors then shifts it down (SHDN); the single RAM read port sets
// the one-entry-per-cycle pace. Dump: n results for n entries, one per cycle while rsp_ch takes
// them, the first loaded in DUMP after the read issued in EVAL. Reset clears the state, entry
// count and result valid; list contents stay unknown until written. A stalled rsp_ch holds the
// result and the dump walk; the next item is taken the cycle after the last result is loaded.
module free_list_release_coalesce_core #(
   parameter int LIST_DEPTH = 32,
   parameter int ADDR_BITS  = 16
) (
   input  logic       clock,
   input  logic       reset,
   flrc_req_if.sink   req_ch,
   flrc_rsp_if.source rsp_ch
);

   flrc_pkg::cmd_type  cmd;
   flrc_pkg::stat_type stat;

   flrc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   flrc_dpath #(
      .LIST_DEPTH (LIST_DEPTH),
      .ADDR_BITS  (ADDR_BITS)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .stat   (stat)
   );

endmodule

// File: hw/rtl/flrc_ram.sv
module flrc_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port; read data holds when not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

// File: hw/rtl/flrc_ctrl.sv
module flrc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  flrc_pkg::stat_type stat,
   output flrc_pkg::cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_EVAL   = 9'b000000010,
      S_SCAN   = 9'b000000100,
      S_DECIDE = 9'b000001000,
      S_SHUP   = 9'b000010000,
      S_INSWR  = 9'b000100000,
      S_SHDN   = 9'b001000000,
      S_DUMP   = 9'b010000000,
      S_FINISH = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (stat.req_valid) begin
               state_in = S_EVAL;
            end
         end

         S_EVAL: begin
            if (stat.is_dump) begin
               if (stat.empty) begin
                  cmd.st_ld  = 1'b1;
                  cmd.st_val = flrc_pkg::ST_EMPTY;
                  state_in   = S_FINISH;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = flrc_pkg::RD_ZERO;
                  cmd.idx_op = flrc_pkg::CTR_CLEAR;
                  state_in   = S_DUMP;
               end
            end else if (stat.ignored) begin
               cmd.st_ld  = 1'b1;
               cmd.st_val = flrc_pkg::ST_IGNORED;
               state_in   = S_FINISH;
            end else if (stat.out_of_range) begin
               cmd.st_ld  = 1'b1;
               cmd.st_val = flrc_pkg::ST_FULL;
               state_in   = S_FINISH;
            end else if (!stat.is_release) begin
               // append at the tail, no merging
               cmd.st_ld = 1'b1;
               if (stat.full) begin
                  cmd.st_val = flrc_pkg::ST_FULL;
               end else begin
                  cmd.st_val = flrc_pkg::ST_INSERTED;
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = flrc_pkg::WR_APPEND;
                  cmd.cnt_op = flrc_pkg::CTR_INC;
               end
               state_in = S_FINISH;
            end else begin
               // release: walk the list for the insertion point
               cmd.idx_op    = flrc_pkg::CTR_CLEAR;
               cmd.at_end_ld = 1'b1;
               if (stat.empty) begin
                  cmd.at_end_val = 1'b1;
                  state_in       = S_DECIDE;
               end else begin
                  cmd.at_end_val = 1'b0;
                  cmd.rd_en      = 1'b1;
                  cmd.rd_sel     = flrc_pkg::RD_ZERO;
                  state_in       = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (stat.scan_le) begin
               cmd.prev_ld = 1'b1;
               cmd.idx_op  = flrc_pkg::CTR_INC;
               if (stat.idx_last) begin
                  cmd.at_end_ld  = 1'b1;
                  cmd.at_end_val = 1'b1;
                  state_in       = S_DECIDE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = flrc_pkg::RD_IDX_NEXT;
               end
            end else begin
               cmd.cur_ld = 1'b1;
               state_in   = S_DECIDE;
            end
         end

         S_DECIDE: begin
            cmd.st_ld = 1'b1;
            if (stat.lower_hit && stat.upper_hit) begin
               cmd.st_val = flrc_pkg::ST_BOTH;
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = flrc_pkg::WR_BOTH;
               if (stat.idx_last) begin
                  cmd.cnt_op = flrc_pkg::CTR_DEC;
                  state_in   = S_FINISH;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = flrc_pkg::RD_IDX_NEXT;
                  cmd.j_op   = flrc_pkg::J_LOAD_NEXT;
                  state_in   = S_SHDN;
               end
            end else if (stat.lower_hit) begin
               cmd.st_val = flrc_pkg::ST_LOWER;
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = flrc_pkg::WR_LOWER;
               state_in   = S_FINISH;
            end else if (stat.upper_hit) begin
               cmd.st_val = flrc_pkg::ST_UPPER;
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = flrc_pkg::WR_UPPER;
               state_in   = S_FINISH;
            end else if (stat.full) begin
               cmd.st_val = flrc_pkg::ST_FULL;
               state_in   = S_FINISH;
            end else if (stat.at_end) begin
               cmd.st_val = flrc_pkg::ST_INSERTED;
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = flrc_pkg::WR_INSERT;
               cmd.cnt_op = flrc_pkg::CTR_INC;
               state_in   = S_FINISH;
            end else begin
               // open a hole: shift the tail up from the last entry
               cmd.st_val = flrc_pkg::ST_INSERTED;
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = flrc_pkg::RD_LAST;
               cmd.j_op   = flrc_pkg::J_LOAD_LAST;
               state_in   = S_SHUP;
            end
         end

         S_SHUP: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = flrc_pkg::WR_SHUP;
            if (stat.j_at_idx) begin
               state_in = S_INSWR;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = flrc_pkg::RD_J_PREV;
               cmd.j_op   = flrc_pkg::J_DEC;
            end
         end

         S_INSWR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = flrc_pkg::WR_INSERT;
            cmd.cnt_op = flrc_pkg::CTR_INC;
            state_in   = S_FINISH;
         end

         S_SHDN: begin
            // close the gap left by the absorbed upper entry
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = flrc_pkg::WR_SHDN;
            if (stat.j_last) begin
               cmd.cnt_op = flrc_pkg::CTR_DEC;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = flrc_pkg::RD_J_NEXT;
               cmd.j_op   = flrc_pkg::J_INC;
            end
         end

         S_DUMP: begin
            if (stat.rsp_free) begin
               cmd.rsp_entry_ld = 1'b1;
               if (stat.idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = flrc_pkg::RD_IDX_NEXT;
                  cmd.idx_op = flrc_pkg::CTR_INC;
               end
            end
         end

         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/flrc_dpath.sv
module flrc_dpath #(
   parameter int LIST_DEPTH = 32,
   parameter int ADDR_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   flrc_req_if.sink           req_ch,
   flrc_rsp_if.source         rsp_ch,
   input  flrc_pkg::cmd_type  cmd,
   output flrc_pkg::stat_type stat
);

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int SUM_W = flrc_pkg::SIZE_W + 1;
   localparam int SPAN_W = 33;
   localparam logic [CW-1:0] ONE_C = CW'(1);
   localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
   localparam logic [SPAN_W-1:0] ADDR_SPAN = SPAN_W'(1) << ADDR_BITS;

   // Captured request
   flrc_pkg::req_code_type type_ff, type_in;
   flrc_pkg::loc_type      loc_ff, loc_in;
   flrc_pkg::size_type     size_ff, size_in;

   // Walk state
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       j_ff, j_in;
   logic                at_end_ff, at_end_in;
   flrc_pkg::entry_type prev_ff, prev_in;
   flrc_pkg::entry_type cur_ff, cur_in;
   flrc_pkg::status_type st_ff, st_in;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   flrc_pkg::status_type rsp_status_ff, rsp_status_in;
   flrc_pkg::loc_type   rsp_loc_ff, rsp_loc_in;
   flrc_pkg::size_type  rsp_size_ff, rsp_size_in;
   logic                rsp_last_ff, rsp_last_in;
   flrc_pkg::count_type rsp_count_ff, rsp_count_in;

   // RAM side
   logic                rd_en, wr_en;
   logic [AW-1:0]       rd_addr, wr_addr;
   flrc_pkg::entry_type wr_data, rd_data;

   logic [CW-1:0]    idx_next, idx_prev, j_next, j_prev, count_last;
   logic [SUM_W-1:0] req_end, prev_end;
   logic [SUM_W:0]   both_len;
   logic             req_accept, rsp_accept;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign rsp_accept = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = cmd.req_ready;

   assign idx_next   = idx_ff + ONE_C;
   assign idx_prev   = idx_ff - ONE_C;
   assign j_next     = j_ff + ONE_C;
   assign j_prev     = j_ff - ONE_C;
   assign count_last = count_ff - ONE_C;

   // End addresses for the touch checks
   assign req_end  = {2'b00, loc_ff} + {1'b0, size_ff};
   assign prev_end = {2'b00, prev_ff.start} + {1'b0, prev_ff.length};
   assign both_len = {2'b00, prev_ff.length} + {2'b00, size_ff} + {2'b00, cur_ff.length};

   // Status toward the controller
   always_comb begin
      stat.req_valid    = req_ch.valid;
      stat.is_dump      = (type_ff == flrc_pkg::REQ_DUMP);
      stat.is_release   = (type_ff == flrc_pkg::REQ_RELEASE);
      stat.ignored      = (type_ff != flrc_pkg::REQ_APPEND) &&
                          (type_ff != flrc_pkg::REQ_RELEASE) || (size_ff == '0);
      stat.out_of_range = (SPAN_W'(req_end) > ADDR_SPAN);
      stat.full         = (count_ff == DEPTH_C);
      stat.empty        = (count_ff == '0);
      stat.scan_le      = (rd_data.start <= loc_ff);
      stat.idx_last     = (idx_next == count_ff);
      stat.at_end       = at_end_ff;
      stat.lower_hit    = (idx_ff != '0) && (prev_end == {2'b00, loc_ff});
      stat.upper_hit    = !at_end_ff && (req_end == {2'b00, cur_ff.start});
      stat.j_at_idx     = (j_ff == idx_ff);
      stat.j_last       = (j_next == count_ff);
      stat.rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   end

   // Read address decode
   always_comb begin
      rd_en = cmd.rd_en;
      unique case (cmd.rd_sel)
         flrc_pkg::RD_ZERO:     rd_addr = '0;
         flrc_pkg::RD_IDX_NEXT: rd_addr = idx_next[AW-1:0];
         flrc_pkg::RD_LAST:     rd_addr = count_last[AW-1:0];
         flrc_pkg::RD_J_NEXT:   rd_addr = j_next[AW-1:0];
         flrc_pkg::RD_J_PREV:   rd_addr = j_prev[AW-1:0];
         default:               rd_addr = '0;
      endcase
   end

   // Write address and data decode
   always_comb begin
      wr_en = cmd.wr_en;
      unique case (cmd.wr_sel)
         flrc_pkg::WR_APPEND: begin
            wr_addr = count_ff[AW-1:0];
            wr_data = '{start: loc_ff, length: size_ff};
         end
         flrc_pkg::WR_INSERT: begin
            wr_addr = idx_ff[AW-1:0];
            wr_data = '{start: loc_ff, length: size_ff};
         end
         flrc_pkg::WR_LOWER: begin
            wr_addr = idx_prev[AW-1:0];
            wr_data = '{start: prev_ff.start,
                        length: flrc_pkg::SIZE_W'(prev_ff.length + size_ff)};
         end
         flrc_pkg::WR_BOTH: begin
            wr_addr = idx_prev[AW-1:0];
            wr_data = '{start: prev_ff.start, length: flrc_pkg::SIZE_W'(both_len)};
         end
         flrc_pkg::WR_UPPER: begin
            wr_addr = idx_ff[AW-1:0];
            wr_data = '{start: loc_ff,
                        length: flrc_pkg::SIZE_W'(cur_ff.length + size_ff)};
         end
         flrc_pkg::WR_SHUP: begin
            wr_addr = j_next[AW-1:0];
            wr_data = rd_data;
         end
         flrc_pkg::WR_SHDN: begin
            wr_addr = j_prev[AW-1:0];
            wr_data = rd_data;
         end
         default: begin
            wr_addr = '0;
            wr_data = rd_data;
         end
      endcase
   end

   flrc_ram #(
      .WIDTH (flrc_pkg::ENTRY_W),
      .DEPTH (LIST_DEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Counters and walk registers
   always_comb begin
      type_in = type_ff;
      loc_in  = loc_ff;
      size_in = size_ff;
      if (req_accept) begin
         type_in = req_ch.req_type;
         loc_in  = req_ch.block_loc;
         size_in = req_ch.block_size;
      end

      case (cmd.idx_op)
         flrc_pkg::CTR_CLEAR: idx_in = '0;
         flrc_pkg::CTR_INC:   idx_in = idx_next;
         flrc_pkg::CTR_DEC:   idx_in = idx_prev;
         default:             idx_in = idx_ff;
      endcase

      case (cmd.cnt_op)
         flrc_pkg::CTR_CLEAR: count_in = '0;
         flrc_pkg::CTR_INC:   count_in = count_ff + ONE_C;
         flrc_pkg::CTR_DEC:   count_in = count_last;
         default:             count_in = count_ff;
      endcase

      case (cmd.j_op)
         flrc_pkg::J_LOAD_LAST: j_in = count_last;
         flrc_pkg::J_LOAD_NEXT: j_in = idx_next;
         flrc_pkg::J_INC:       j_in = j_next;
         flrc_pkg::J_DEC:       j_in = j_prev;
         default:               j_in = j_ff;
      endcase

      at_end_in = cmd.at_end_ld ? cmd.at_end_val : at_end_ff;
      prev_in   = cmd.prev_ld ? rd_data : prev_ff;
      cur_in    = cmd.cur_ld ? rd_data : cur_ff;
      st_in     = cmd.st_ld ? cmd.st_val : st_ff;
   end

   // Response register: loads when free or being taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_loc_in    = rsp_loc_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_entry_ld) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = flrc_pkg::ST_ENTRY;
         rsp_loc_in    = rd_data.start;
         rsp_size_in   = rd_data.length;
         rsp_last_in   = stat.idx_last;
         rsp_count_in  = flrc_pkg::COUNT_W'(count_ff);
      end else if (cmd.rsp_ld) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = st_ff;
         rsp_loc_in    = '0;
         rsp_size_in   = '0;
         rsp_last_in   = 1'b1;
         rsp_count_in  = flrc_pkg::COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      loc_ff        <= loc_in;
      size_ff       <= size_in;
      idx_ff        <= idx_in;
      j_ff          <= j_in;
      at_end_ff     <= at_end_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_loc_ff    <= rsp_loc_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_loc   = rsp_loc_ff;
   assign rsp_ch.entry_size  = rsp_size_ff;
   assign rsp_ch.last        = rsp_last_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

endmodule

// File: hw/rtl/flrc_checker.sv
module flrc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [flrc_pkg::STATUS_W-1:0] rsp_status,
   input flrc_pkg::loc_type             rsp_entry_loc,
   input flrc_pkg::size_type            rsp_entry_size,
   input logic                          rsp_last,
   input flrc_pkg::count_type           rsp_entry_count
);

   // Only dump entries can be non-final
   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != flrc_pkg::ST_ENTRY) |-> rsp_last)
      else $error("non-entry result without last");

   // Non-entry results carry zero entry fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != flrc_pkg::ST_ENTRY) |->
         (rsp_entry_loc == '0) && (rsp_entry_size == '0))
      else $error("entry fields set on a non-entry result");

   // An empty dump reports an empty list
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == flrc_pkg::ST_EMPTY) |-> (rsp_entry_count == '0))
      else $error("empty dump with nonzero count");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_entry_loc) && $stable(rsp_entry_size) && $stable(rsp_last))
      else $error("result changed while stalled");

endmodule

bind free_list_release_coalesce_core flrc_checker u_flrc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_entry_loc   (rsp_ch.entry_loc),
   .rsp_entry_size  (rsp_ch.entry_size),
   .rsp_last        (rsp_ch.last),
   .rsp_entry_count (rsp_ch.entry_count)
);
